// ===== sv/hst_pkg.sv =====
package hst_pkg;

   localparam int ENTRIES   = 64;
   localparam int ADDR_BITS = 32;

   localparam int HASH_W  = 63;
   localparam int STORE_W = (ADDR_BITS < 32) ? ADDR_BITS : 32;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int ENTRY_W = HASH_W + STORE_W;

   localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_FIND  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FOUND    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic [HASH_W-1:0]  hash;
      logic [STORE_W-1:0] addr;
   } cmd_type;

   // xor in the byte, then multiply by the prime 2^40 + 0x1b3 as shifts and adds
   function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

// ===== sv/hst_ram.sv =====
module hst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/hst_front.sv =====
module hst_front
   import hst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_id_byte,
   input  logic        req_byte_valid,
   input  logic        req_last_byte,
   input  logic [31:0] req_new_addr,
   input  logic        req_push,
   output logic        req_full,
   input  logic        q_full,
   output logic        q_push,
   output cmd_type     q_cmd
);

   logic [63:0] hash_ff;
   logic [63:0] hash_in;
   logic [63:0] next_hash;
   logic        accept;

   assign req_full  = q_full;
   assign accept    = req_push && !q_full;
   assign next_hash = req_byte_valid ? fnv_step(hash_ff, req_id_byte) : hash_ff;

   always_comb begin
      hash_in = hash_ff;
      if (accept) begin
         hash_in = req_last_byte ? FNV_BASIS : next_hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
      end else begin
         hash_ff <= hash_in;
      end
   end

   assign q_push     = accept && req_last_byte;
   assign q_cmd.op   = req_opcode;
   assign q_cmd.hash = next_hash[HASH_W-1:0];
   assign q_cmd.addr = req_new_addr[STORE_W-1:0];

endmodule

// ===== sv/hst_cmdq.sv =====
module hst_cmdq
   import hst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       do_push;
   logic       do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/hst_back.sv =====
module hst_back
   import hst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_found_addr,
   output logic [62:0] rsp_id_hash,
   output logic        rsp_empty,
   input  logic        rsp_pop
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_RESP   = 2'd2;

   logic [1:0]         state_ff;
   logic [1:0]         state_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   idx_in;
   logic [HASH_W-1:0]  hash_ff;
   logic [HASH_W-1:0]  hash_in;
   logic [1:0]         res_status_ff;
   logic [1:0]         res_status_in;
   logic [STORE_W-1:0] res_addr_ff;
   logic [STORE_W-1:0] res_addr_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [1:0]         out_status_ff;
   logic [1:0]         out_status_in;
   logic [31:0]        out_addr_ff;
   logic [31:0]        out_addr_in;
   logic [HASH_W-1:0]  out_hash_ff;
   logic [HASH_W-1:0]  out_hash_in;
   logic               out_free;
   logic [CNT_W-1:0]   cnt_m1;
   logic               wr_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [HASH_W-1:0]  rd_hash;
   logic [STORE_W-1:0] rd_addr_val;

   assign out_free    = !out_valid_ff || rsp_pop;
   assign cnt_m1      = cnt_ff - CNT_W'(1);
   assign rd_hash     = rd_data[ENTRY_W-1:STORE_W];
   assign rd_addr_val = rd_data[STORE_W-1:0];
   assign q_pop       = (state_ff == S_IDLE) && !q_empty;
   assign wr_en       = q_pop && (q_cmd.op == OP_ADD) && (cnt_ff < CNT_W'(ENTRIES));
   assign rd_addr     = (state_ff == S_IDLE) ? cnt_m1[IDX_W-1:0] : idx_ff - IDX_W'(1);

   hst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_data ({q_cmd.hash, q_cmd.addr}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      hash_in       = hash_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      out_valid_in  = out_valid_ff && !rsp_pop;
      out_status_in = out_status_ff;
      out_addr_in   = out_addr_ff;
      out_hash_in   = out_hash_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               hash_in       = q_cmd.hash;
               res_status_in = ST_OK;
               res_addr_in   = '0;
               state_in      = S_RESP;
               case (q_cmd.op)
                  OP_ADD: begin
                     if (wr_en) begin
                        cnt_in = cnt_ff + CNT_W'(1);
                     end else begin
                        res_status_in = ST_FULL;
                     end
                  end
                  OP_FIND: begin
                     res_status_in = ST_NOTFOUND;
                     if (cnt_ff != '0) begin
                        idx_in   = cnt_m1[IDX_W-1:0];
                        state_in = S_SEARCH;
                     end
                  end
                  OP_CLEAR: begin
                     cnt_in = '0;
                  end
                  default: begin
                     res_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (rd_hash == hash_ff) begin
               res_status_in = ST_FOUND;
               res_addr_in   = rd_addr_val;
               state_in      = S_RESP;
            end else if (idx_ff == '0) begin
               state_in = S_RESP;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         S_RESP: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_addr_in   = 32'(res_addr_ff);
               out_hash_in   = hash_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      hash_ff       <= hash_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      out_status_ff <= out_status_in;
      out_addr_ff   <= out_addr_in;
      out_hash_ff   <= out_hash_in;
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_found_addr = out_addr_ff;
   assign rsp_id_hash    = out_hash_ff;

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(ENTRIES))
      else $error("entry count beyond table size");

   a_search_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (CNT_W'(idx_ff) < cnt_ff))
      else $error("search index outside filled entries");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_status_ff != ST_FOUND)) |-> (out_addr_ff == '0))
      else $error("address reported without a match");

   a_no_write_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |=> $stable(cnt_ff))
      else $error("table changed during search");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> (out_valid_ff && $stable(out_hash_ff)))
      else $error("waiting item overwritten");
`endif

endmodule

// ===== sv/hashed_symbol_table_unit.sv =====
// channel   direction  handshake             fields
// req       in         req_push / req_full   opcode, id_byte, byte_valid, last_byte, new_addr
// rsp       out        rsp_empty / rsp_pop   status, found_addr, id_hash
//
// name bytes are taken one per cycle while req_full is low; only the last item of a name yields an item on rsp
// add, clear and unused opcodes go from idle straight to the response state in the table engine;
// find first searches the filled entries, one table entry read per cycle from the entry ram
// a 2-deep command queue lets bytes keep hashing while the table engine searches
// reset clears the running hash, the queue, the entry count and the output register
module hashed_symbol_table_unit
   import hst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_id_byte,
   input  logic        req_byte_valid,
   input  logic        req_last_byte,
   input  logic [31:0] req_new_addr,
   input  logic        req_push,
   output logic        req_full,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_found_addr,
   output logic [62:0] rsp_id_hash,
   output logic        rsp_empty,
   input  logic        rsp_pop
);

   cmd_type push_cmd;
   cmd_type pop_cmd;
   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;

   hst_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_opcode     (req_opcode),
      .req_id_byte    (req_id_byte),
      .req_byte_valid (req_byte_valid),
      .req_last_byte  (req_last_byte),
      .req_new_addr   (req_new_addr),
      .req_push       (req_push),
      .req_full       (req_full),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (push_cmd)
   );

   hst_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   hst_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_cmd          (pop_cmd),
      .q_pop          (q_pop),
      .rsp_status     (rsp_status),
      .rsp_found_addr (rsp_found_addr),
      .rsp_id_hash    (rsp_id_hash),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop)
   );

endmodule
